/* rtl/assert_macros.svh */
// Assertion macros for the set-associative tag store.
// No dependencies; included by the RTL files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked on clk_i, disabled while rst_ni is low.
`define SATS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked on clk_i, also checked during reset.
`define SATS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SATS_ASSERT(name, prop, msg)
`define SATS_ASSERT_RST(name, prop, msg)
`endif

`endif

/* rtl/sats_pkg.sv */
// Shared types and constants of the set-associative tag store.
// No dependencies.
`default_nettype none

package sats_pkg;

  localparam int SATS_MAX_SET_BITS = 6;
  localparam int SATS_WAYS         = 8;

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Coherence codes used by the logic
  localparam logic [1:0] COH_INVALID  = 2'd0;
  localparam logic [1:0] COH_MODIFIED = 2'd3;

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [2:0] RST_SET_BITS    = 3'd6;
  localparam logic [3:0] RST_OFFSET_BITS = 4'd6;
  localparam logic [3:0] RST_WAYS_IN_USE = 4'd8;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] offset_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  // One way of one set
  typedef struct packed {
    logic [31:0] tag;
    logic        valid;
    logic        dirty;
    logic [1:0]  coh;
    logic [31:0] stamp;
  } line_t;

  // Verdict of the shared way compare unit
  typedef struct packed {
    logic match;    // valid and tag equal
    logic replace;  // better replacement candidate
  } way_res_t;

endpackage

`default_nettype wire

/* rtl/sats_req_if.sv */
// Request channel of the tag store: valid/ready plus the request fields.
// No dependencies.
`default_nettype none

interface sats_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] address;
  logic [1:0]  line_state;
  logic [31:0] time_stamp;

  modport source (output valid, cmd, address, line_state, time_stamp, input ready);
  modport sink   (input valid, cmd, address, line_state, time_stamp, output ready);
endinterface

`default_nettype wire

/* rtl/sats_rsp_if.sv */
// Result channel of the tag store: valid/ready plus the result fields.
// No dependencies.
`default_nettype none

interface sats_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [2:0]  hit_way;
  logic [1:0]  found_state;
  logic        evicted;
  logic        evicted_dirty;
  logic [31:0] eviction_total;
  logic [31:0] dirty_eviction_total;
  logic [31:0] fill_total;

  modport source (output valid, hit, hit_way, found_state, evicted, evicted_dirty,
                  eviction_total, dirty_eviction_total, fill_total, input ready);
  modport sink   (input valid, hit, hit_way, found_state, evicted, evicted_dirty,
                  eviction_total, dirty_eviction_total, fill_total, output ready);
endinterface

`default_nettype wire

/* rtl/sats_cfg_regs.sv */
// APB-style configuration registers of the tag store.
// Depends on sats_pkg.
`default_nettype none

module sats_cfg_regs
  import sats_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= RST_SET_BITS;
      cfg_q.offset_bits <= RST_OFFSET_BITS;
      cfg_q.ways_in_use <= RST_WAYS_IN_USE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SET_BITS:    cfg_q.set_bits    <= pwdata[2:0];
        REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[3:0];
        REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_SET_BITS:    prdata = {29'd0, cfg_q.set_bits};
      REG_OFFSET_BITS: prdata = {28'd0, cfg_q.offset_bits};
      REG_WAYS_IN_USE: prdata = {28'd0, cfg_q.ways_in_use};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sats_way_unit.sv */
// Shared way compare unit: tag match and LRU candidate test for one way.
// Depends on sats_pkg.
`default_nettype none

module sats_way_unit
  import sats_pkg::*;
(
  input  wire line_t       line_i,
  input  wire logic [31:0] tag_i,
  input  wire logic [31:0] best_time_i,
  input  wire logic        first_i,
  output way_res_t         res_o
);

  // Hit test, and replacement: first way, an invalid way, or a strictly older stamp
  assign res_o.match   = line_i.valid && (line_i.tag == tag_i);
  assign res_o.replace = first_i || !line_i.valid || (line_i.stamp < best_time_i);

endmodule

`default_nettype wire

/* rtl/set_assoc_tag_store_lru.sv */
// Top level of the set-associative tag store with timestamp LRU.
// Depends on sats_pkg, sats_req_if, sats_rsp_if, sats_cfg_regs, sats_way_unit.
//
//  channel | dir | transfer when       | carries
//  req_i   | in  | valid && ready      | cmd, address, line_state, time_stamp
//  rsp_o   | out | valid && ready      | hit, hit_way, found_state, evictions, totals
//  apb     | in  | psel&penable&pwrite | set_bits, offset_bits, ways_in_use
//
// The set row is read at the request transfer; the ways in use (at most WAYS) then
// pass one way per cycle through the shared compare unit, and the row is written
// back in the write-back state, which also loads the result register. The way
// scan is skipped for the unused command or with no ways in use.
// After reset a clearing pass writes every set row, with req_i.ready low.
// A stalled result holds the block in write back until taken.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_tag_store_lru
  import sats_pkg::*;
#(
  parameter int MAX_SET_BITS = SATS_MAX_SET_BITS,
  parameter int WAYS         = SATS_WAYS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sats_req_if.sink         req_i,
  sats_rsp_if.source       rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SIDX     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WIDX     = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WB
  } state_e;

  // Configuration
  cfg_t cfg;

  sats_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective set bits and way count
  logic [2:0]  sb;
  logic [3:0]  nw;
  logic [31:0] shifted;
  logic [31:0] set_mask;
  logic [SIDX-1:0] set_in;
  logic [31:0] tag_in;

  assign sb       = (32'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
  assign nw       = (32'(cfg.ways_in_use) > WAYS) ? 4'(WAYS) : cfg.ways_in_use;
  assign shifted  = req_i.address >> cfg.offset_bits;
  assign set_mask = (32'd1 << sb) - 32'd1;
  assign set_in   = SIDX'(shifted & set_mask);
  assign tag_in   = req_i.address >> (5'(sb) + 5'(cfg.offset_bits));

  // Sequencer and datapath registers
  state_e          state_q;
  logic [SIDX-1:0] clr_q;
  cmd_e            cmd_q;
  logic [SIDX-1:0] set_q;
  logic [31:0]     tag_q;
  logic [1:0]      st_q;
  logic [31:0]     time_q;
  logic [WIDX-1:0] way_q;
  logic            hit_q;
  logic [WIDX-1:0] hit_way_q;
  logic [1:0]      fstate_q;
  logic [WIDX-1:0] best_q;
  logic [31:0]     best_time_q;
  logic [WAYS-1:0] inval_mask_q;
  logic [31:0]     ev_cnt_q;
  logic [31:0]     evd_cnt_q;
  logic [31:0]     fill_cnt_q;

  // Result register
  logic        rsp_valid_q;
  logic        rsp_hit_q;
  logic [2:0]  rsp_way_q;
  logic [1:0]  rsp_fstate_q;
  logic        rsp_ev_q;
  logic        rsp_evd_q;
  logic [31:0] rsp_ev_tot_q;
  logic [31:0] rsp_evd_tot_q;
  logic [31:0] rsp_fill_tot_q;

  // Set memory, one row per set, with registered read
  line_t [WAYS-1:0] mem_q [NUM_SETS];
  line_t [WAYS-1:0] rd_q;
  line_t [WAYS-1:0] wr_row;
  logic             mem_we;
  logic [SIDX-1:0]  mem_waddr;

  logic in_xfer;
  logic out_free;
  logic last_way;
  logic active;
  logic wb_done;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_xfer     = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign last_way    = (5'(way_q) + 5'd1) == 5'(nw);
  assign active      = (cmd_e'(req_i.cmd) != CMD_NONE) && (nw != 4'd0);
  assign wb_done     = (state_q == ST_WB) && out_free;

  // Shared way compare unit
  way_res_t way_res;

  sats_way_unit u_way (
    .line_i      (rd_q[way_q]),
    .tag_i       (tag_q),
    .best_time_i (best_time_q),
    .first_i     (way_q == '0),
    .res_o       (way_res)
  );

  // Write-back row and eviction result
  line_t victim;
  logic  do_fill;
  logic  ev;
  logic  evd;

  assign victim  = rd_q[best_q];
  assign do_fill = (cmd_q == CMD_FILL) && (nw != 4'd0);
  assign ev      = do_fill && victim.valid;
  assign evd     = ev && victim.dirty;

  always_comb begin
    wr_row = rd_q;
    case (cmd_q)
      CMD_LOOKUP: begin
        if (hit_q) wr_row[hit_way_q].stamp = time_q;
      end
      CMD_INVAL: begin
        for (int w = 0; w < WAYS; w++) begin
          if (inval_mask_q[w]) wr_row[w].coh = COH_INVALID;
        end
      end
      CMD_FILL: begin
        if (do_fill) begin
          wr_row[best_q].tag   = tag_q;
          wr_row[best_q].valid = 1'b1;
          wr_row[best_q].dirty = (st_q == COH_MODIFIED);
          wr_row[best_q].coh   = st_q;
          wr_row[best_q].stamp = time_q;
        end
      end
      default: ;
    endcase
  end

  assign mem_we    = (state_q == ST_CLEAR) || wb_done;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;

  // Memory port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= (state_q == ST_CLEAR) ? '0 : wr_row;
    if (in_xfer) rd_q <= mem_q[set_in];
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      cmd_q          <= CMD_NONE;
      set_q          <= '0;
      tag_q          <= '0;
      st_q           <= '0;
      time_q         <= '0;
      way_q          <= '0;
      hit_q          <= 1'b0;
      hit_way_q      <= '0;
      fstate_q       <= '0;
      best_q         <= '0;
      best_time_q    <= '0;
      inval_mask_q   <= '0;
      ev_cnt_q       <= '0;
      evd_cnt_q      <= '0;
      fill_cnt_q     <= '0;
      rsp_valid_q    <= 1'b0;
      rsp_hit_q      <= 1'b0;
      rsp_way_q      <= '0;
      rsp_fstate_q   <= '0;
      rsp_ev_q       <= 1'b0;
      rsp_evd_q      <= 1'b0;
      rsp_ev_tot_q   <= '0;
      rsp_evd_tot_q  <= '0;
      rsp_fill_tot_q <= '0;
    end else begin
      // result valid: set on write back, cleared when taken
      if (wb_done)          rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SIDX'(NUM_SETS - 1)) state_q <= ST_IDLE;
        end

        ST_IDLE: begin
          if (in_xfer) begin
            cmd_q        <= cmd_e'(req_i.cmd);
            set_q        <= set_in;
            tag_q        <= tag_in;
            st_q         <= req_i.line_state;
            time_q       <= req_i.time_stamp;
            way_q        <= '0;
            hit_q        <= 1'b0;
            hit_way_q    <= '0;
            fstate_q     <= '0;
            best_q       <= '0;
            best_time_q  <= '0;
            inval_mask_q <= '0;
            state_q      <= active ? ST_SCAN : ST_WB;
          end
        end

        ST_SCAN: begin
          // one way per cycle through the shared unit
          if (cmd_q == CMD_FILL) begin
            if (way_res.replace) begin
              best_q      <= way_q;
              best_time_q <= rd_q[way_q].stamp;
            end
          end else begin
            if (way_res.match && !hit_q) begin
              hit_q     <= 1'b1;
              hit_way_q <= way_q;
              fstate_q  <= rd_q[way_q].coh;
            end
            if (way_res.match && (cmd_q == CMD_INVAL)) inval_mask_q[way_q] <= 1'b1;
          end
          if (last_way) state_q <= ST_WB;
          else          way_q   <= way_q + 1'b1;
        end

        ST_WB: begin
          if (out_free) begin
            rsp_hit_q      <= (cmd_q == CMD_LOOKUP || cmd_q == CMD_INVAL) && hit_q;
            rsp_way_q      <= (cmd_q == CMD_FILL) ? 3'(best_q) : 3'(hit_way_q);
            rsp_fstate_q   <= (cmd_q == CMD_FILL) ? 2'd0 : fstate_q;
            rsp_ev_q       <= ev;
            rsp_evd_q      <= evd;
            rsp_ev_tot_q   <= ev_cnt_q + 32'(ev);
            rsp_evd_tot_q  <= evd_cnt_q + 32'(evd);
            rsp_fill_tot_q <= fill_cnt_q + 32'(cmd_q == CMD_FILL);
            ev_cnt_q       <= ev_cnt_q + 32'(ev);
            evd_cnt_q      <= evd_cnt_q + 32'(evd);
            fill_cnt_q     <= fill_cnt_q + 32'(cmd_q == CMD_FILL);
            state_q        <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid                = rsp_valid_q;
  assign rsp_o.hit                  = rsp_hit_q;
  assign rsp_o.hit_way              = rsp_way_q;
  assign rsp_o.found_state          = rsp_fstate_q;
  assign rsp_o.evicted              = rsp_ev_q;
  assign rsp_o.evicted_dirty        = rsp_evd_q;
  assign rsp_o.eviction_total       = rsp_ev_tot_q;
  assign rsp_o.dirty_eviction_total = rsp_evd_tot_q;
  assign rsp_o.fill_total           = rsp_fill_tot_q;

  // Assertions
  `SATS_ASSERT(a_busy_after_xfer, in_xfer |=> !req_i.ready, "ready after request transfer")
  `SATS_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (5'(way_q) < 5'(nw)),
               "way scan beyond ways in use")
  `SATS_ASSERT(a_dirty_implies_ev,
               (evd_cnt_q != $past(evd_cnt_q)) |-> (ev_cnt_q != $past(ev_cnt_q)),
               "dirty eviction counted without eviction")
  `SATS_ASSERT(a_fill_count,
               (wb_done && (cmd_q == CMD_FILL)) |=> (fill_cnt_q == $past(fill_cnt_q) + 32'd1),
               "fill not counted")
  `SATS_ASSERT_RST(a_no_rsp_in_clear, (state_q == ST_CLEAR) |-> !rsp_valid_q,
                   "result while clearing")

endmodule

`default_nettype wire

/* verif/tb_checker.sv */
// Scoreboard for the set-associative tag store: watches the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on sats_pkg, sats_req_if and sats_rsp_if.
`default_nettype none

module tb_checker
  import sats_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sats_req_if              req_mon,
  sats_rsp_if              rsp_mon,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               mismatch_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHADOW_DEPTH = (2 ** SATS_MAX_SET_BITS) * SATS_WAYS;

  typedef struct packed {
    bit        hit;
    bit [2:0]  way;
    bit [1:0]  found_state;
    bit        evicted;
    bit        evicted_dirty;
    bit [31:0] eviction_total;
    bit [31:0] dirty_eviction_total;
    bit [31:0] fill_total;
  } tag_result_t;

  // Shadow copy of the tag array and counters
  bit [31:0] shadow_tag   [SHADOW_DEPTH];
  bit        shadow_valid [SHADOW_DEPTH];
  bit        shadow_dirty [SHADOW_DEPTH];
  bit [1:0]  shadow_coh   [SHADOW_DEPTH];
  bit [31:0] shadow_stamp [SHADOW_DEPTH];
  bit [31:0] evict_cnt, dirty_evict_cnt, fill_cnt;

  bit [2:0] cfg_set_bits;
  bit [3:0] cfg_offset_bits;
  bit [3:0] cfg_ways;

  tag_result_t expected_results[$];
  int          n_bad;

  // Apply one access to the shadow store and return the result it produces
  function automatic tag_result_t access_tag_store(bit [1:0] cmd_v, bit [31:0] addr,
                                                   bit [1:0] state_v, bit [31:0] now_v);
    tag_result_t r;
    int unsigned sb, nw, base, idx, best;
    bit [31:0]   set_idx, tag, best_time;
    bit          have;
    r = '0;
    sb = (cfg_set_bits > SATS_MAX_SET_BITS) ? SATS_MAX_SET_BITS : cfg_set_bits;
    nw = (cfg_ways > SATS_WAYS) ? SATS_WAYS : cfg_ways;
    set_idx = (addr >> cfg_offset_bits) & ((32'd1 << sb) - 32'd1);
    tag = addr >> (sb + cfg_offset_bits);
    base = set_idx * SATS_WAYS;
    case (cmd_e'(cmd_v))
      CMD_LOOKUP, CMD_INVAL: begin
        // first matching way reports; invalidate clears every match
        for (int unsigned w = 0; w < nw; w++) begin
          idx = base + w;
          if (shadow_valid[idx] && shadow_tag[idx] == tag) begin
            if (!r.hit) begin
              r.hit = 1'b1;
              r.way = w[2:0];
              r.found_state = shadow_coh[idx];
              if (cmd_e'(cmd_v) == CMD_LOOKUP) shadow_stamp[idx] = now_v;
            end
            if (cmd_e'(cmd_v) == CMD_INVAL) shadow_coh[idx] = COH_INVALID;
          end
        end
      end
      CMD_FILL: begin
        have = 1'b0;
        best = 0;
        best_time = '0;
        fill_cnt++;
        // last way that is invalid or strictly older wins
        for (int unsigned w = 0; w < nw; w++) begin
          idx = base + w;
          if (!have || !shadow_valid[idx] || shadow_stamp[idx] < best_time) begin
            have = 1'b1;
            best = w;
            best_time = shadow_stamp[idx];
          end
        end
        if (have) begin
          idx = base + best;
          if (shadow_valid[idx]) begin
            r.evicted = 1'b1;
            evict_cnt++;
            if (shadow_dirty[idx]) begin
              r.evicted_dirty = 1'b1;
              dirty_evict_cnt++;
            end
          end
          shadow_tag[idx]   = tag;
          shadow_valid[idx] = 1'b1;
          shadow_dirty[idx] = (state_v == COH_MODIFIED);
          shadow_coh[idx]   = state_v;
          shadow_stamp[idx] = now_v;
          r.way = best[2:0];
        end
      end
      default: ;
    endcase
    r.eviction_total       = evict_cnt;
    r.dirty_eviction_total = dirty_evict_cnt;
    r.fill_total           = fill_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, bit [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      n_bad++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tag_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < SHADOW_DEPTH; i++) begin
        shadow_tag[i]   = '0;
        shadow_valid[i] = 1'b0;
        shadow_dirty[i] = 1'b0;
        shadow_coh[i]   = COH_INVALID;
        shadow_stamp[i] = '0;
      end
      evict_cnt = '0;
      dirty_evict_cnt = '0;
      fill_cnt = '0;
      cfg_set_bits = RST_SET_BITS;
      cfg_offset_bits = RST_OFFSET_BITS;
      cfg_ways = RST_WAYS_IN_USE;
      expected_results.delete();
      n_bad = 0;
      mismatch_count <= 0;
      pending_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {REG_SET_BITS, 2'b00}:    cfg_set_bits = pwdata[2:0];
          {REG_OFFSET_BITS, 2'b00}: cfg_offset_bits = pwdata[3:0];
          {REG_WAYS_IN_USE, 2'b00}: cfg_ways = pwdata[3:0];
          default: ;
        endcase
      end
      // result transfer: compare with the oldest expectation
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          n_bad++;
          $display("%0t: result with nothing expected: hit %b way %0d", $time,
                   rsp_mon.hit, rsp_mon.hit_way);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("hit", 32'(exp_r.hit), 32'(rsp_mon.hit));
          check_field("hit_way", 32'(exp_r.way), 32'(rsp_mon.hit_way));
          check_field("found_state", 32'(exp_r.found_state), 32'(rsp_mon.found_state));
          check_field("evicted", 32'(exp_r.evicted), 32'(rsp_mon.evicted));
          check_field("evicted_dirty", 32'(exp_r.evicted_dirty),
                      32'(rsp_mon.evicted_dirty));
          check_field("eviction_total", exp_r.eviction_total, rsp_mon.eviction_total);
          check_field("dirty_eviction_total", exp_r.dirty_eviction_total,
                      rsp_mon.dirty_eviction_total);
          check_field("fill_total", exp_r.fill_total, rsp_mon.fill_total);
        end
      end
      // request transfer: predict its result
      if (req_mon.valid && req_mon.ready) begin
        expected_results.push_back(access_tag_store(req_mon.cmd, req_mon.address,
                                                    req_mon.line_state, req_mon.time_stamp));
      end
      mismatch_count <= n_bad;
      pending_count <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Top of the tag store testbench: clock, reset, register writes, request
// stimulus and result back-pressure; the verdict comes from tb_checker.
// Depends on sats_pkg, both channel interfaces, tb_checker and the RTL top.
`default_nettype none

module tb_top;
  import sats_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count, pending_count;

  sats_req_if req_if ();
  sats_rsp_if rsp_if ();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // current register values, used to aim addresses at few sets
  bit [2:0]  cur_set_bits = RST_SET_BITS;
  bit [3:0]  cur_offset_bits = RST_OFFSET_BITS;
  bit [31:0] now_ts = 0;
  bit [31:0] addr_pool[$];

  set_assoc_tag_store_lru u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tb_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // result back-pressure
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // one request transfer, after a random gap
  task automatic send_req(cmd_e cmd_v, bit [31:0] addr, bit [1:0] state_v, bit [31:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd_v;
    req_if.address    <= addr;
    req_if.line_state <= state_v;
    req_if.time_stamp <= ts;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // setup then access phase; upper data bits are don't-care
  task automatic write_reg(bit [1:0] idx, bit [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {$urandom} & 32'hFFFF_FFF0 | {28'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and let every expected result come back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic bit [31:0] pick_address();
    int unsigned sb, ob, r;
    bit [31:0]   tag, set_idx, offs;
    r = $urandom_range(99);
    sb = (cur_set_bits > SATS_MAX_SET_BITS) ? SATS_MAX_SET_BITS : cur_set_bits;
    ob = cur_offset_bits;
    if (addr_pool.size() != 0 && r < 45) return addr_pool[$urandom_range(addr_pool.size() - 1)];
    if (r < 60) return $urandom;
    // few tags on few sets, so that sets fill up and lines get replaced
    tag = (r < 90) ? $urandom_range(11) : $urandom;
    set_idx = $urandom_range(2) & ((32'd1 << sb) - 32'd1);
    offs = $urandom & ((32'd1 << ob) - 32'd1);
    return (tag << (sb + ob)) | (set_idx << ob) | offs;
  endfunction

  function automatic bit [31:0] next_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return $urandom;
    if (r < 6) return 32'd0;
    if (r < 8) return 32'hFFFF_FFFF;
    now_ts += $urandom_range(3);
    return now_ts;
  endfunction

  task automatic send_random(int count);
    int unsigned r;
    bit [31:0]   addr;
    cmd_e        cmd_v;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      cmd_v = (r < 40) ? CMD_LOOKUP : (r < 75) ? CMD_FILL : (r < 93) ? CMD_INVAL : CMD_NONE;
      addr = pick_address();
      addr_pool.push_back(addr);
      if (addr_pool.size() > 24) void'(addr_pool.pop_front());
      send_req(cmd_v, addr, 2'($urandom_range(3)), next_stamp());
    end
  endtask

  // idle mode: 0 none, 1 sender, 2 receiver, 3 both
  task automatic set_idle(int mode);
    send_idle_pct  = (mode == 1) ? 81 : (mode == 3) ? 35 : 0;
    recv_stall_pct = (mode == 2) ? 81 : (mode == 3) ? 35 : 0;
  endtask

  initial begin
    static bit [3:0] phase_cfg[8][3] = '{
      '{4'd0, 4'd0,  4'd1},   // one way, no set bits, no offset
      '{4'd7, 4'd15, 4'd15},  // over-range values saturate or pass through
      '{4'd2, 4'd12, 4'd0},   // no ways in use
      '{4'd6, 4'd6,  4'd8},
      '{4'd1, 4'd3,  4'd2},
      '{4'd3, 4'd8,  4'd5},
      '{4'd0, 4'd0,  4'd0},   // replaced by random values below
      '{4'd4, 4'd12, 4'd8}
    };
    bit [3:0] sb_v, ob_v, nw_v;

    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.cmd         <= CMD_LOOKUP;
    req_if.address     <= '0;
    req_if.line_state  <= COH_INVALID;
    req_if.time_stamp  <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with reset settings: six set bits, six offset bits
    set_idle(0);
    send_req(CMD_LOOKUP, 32'h0, COH_INVALID, 32'h0);
    send_req(CMD_FILL, 32'hFFFF_FFFF, 2'd2, 32'hFFFF_FFFF);
    send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 2'd1, 32'h0);
    send_req(CMD_INVAL, 32'hFFFF_FFFF, 2'd3, 32'h5);
    // an invalidated line keeps valid set and reports state zero
    send_req(CMD_LOOKUP, 32'hFFFF_FFC0, COH_INVALID, 32'h6);
    // fill set 0 with tags 1..8, stamps paired so some are tied
    for (int k = 1; k <= 8; k++)
      send_req(CMD_FILL, k << 12, 2'(k % 4), 100 + k / 2);
    send_req(CMD_FILL, 32'd9 << 12, COH_MODIFIED, 32'd120);
    send_req(CMD_FILL, 32'd10 << 12, 2'd1, 32'd121);
    send_req(CMD_LOOKUP, 32'd3 << 12, COH_INVALID, 32'd130);
    send_req(CMD_INVAL, 32'd5 << 12, COH_INVALID, 32'd131);
    send_req(CMD_LOOKUP, 32'd5 << 12, COH_INVALID, 32'd132);
    // the same tag filled twice; invalidate then clears both copies
    send_req(CMD_FILL, 32'd6 << 12, COH_MODIFIED, 32'd133);
    send_req(CMD_INVAL, 32'd6 << 12, COH_INVALID, 32'd134);
    send_req(CMD_LOOKUP, 32'd6 << 12, COH_INVALID, 32'd135);
    send_req(CMD_NONE, 32'hFFFF_FFFF, COH_MODIFIED, 32'hFFFF_FFFF);
    send_req(CMD_FILL, 32'h0, COH_INVALID, 32'h0);
    send_req(CMD_LOOKUP, 32'h0, COH_INVALID, 32'h0);
    now_ts = 200;
    drain();

    // random phases, each with its own register settings and idle mode
    for (int p = 0; p < 8; p++) begin
      sb_v = phase_cfg[p][0];
      ob_v = phase_cfg[p][1];
      nw_v = phase_cfg[p][2];
      if (p == 6) begin
        sb_v = $urandom_range(7);
        ob_v = $urandom_range(15);
        nw_v = $urandom_range(15);
      end
      write_reg(REG_SET_BITS, sb_v);
      write_reg(REG_OFFSET_BITS, ob_v);
      write_reg(REG_WAYS_IN_USE, nw_v);
      cur_set_bits = sb_v[2:0];
      cur_offset_bits = ob_v;
      addr_pool.delete();
      set_idle(p % 4);
      send_random(85);
      drain();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
